[rtl/core/pngse_pkg.sv]
// Package: types, constants and checksum helpers for the PNG stream encoder.
`timescale 1ns / 1ps
package pngse_pkg;

  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxHeight = 4096;
  localparam int CfgWidth     = 13;
  localparam logic [31:0] CrcPoly  = 32'hedb88320;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [2:0] AddrWidth  = 3'd0;
  localparam logic [2:0] AddrHeight = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [15:0] pixel;
  } pngse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_last;
  } pngse_out_t;

  typedef struct packed {
    logic init;
    logic hdr_en;
    logic idat_en;
    logic adler_en;
  } pngse_sum_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HEAD = 5'b00010,
    ST_ROWH = 5'b00100,
    ST_PIX  = 5'b01000,
    ST_TAIL = 5'b10000
  } pngse_state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] head_const(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd0: v = 8'd137;  6'd1: v = 8'd80;  6'd2: v = 8'd78;  6'd3: v = 8'd71;
      6'd4: v = 8'd13;   6'd5: v = 8'd10;  6'd6: v = 8'd26;  6'd7: v = 8'd10;
      6'd11: v = 8'd13;
      6'd12: v = 8'h49;  6'd13: v = 8'h48; 6'd14: v = 8'h44; 6'd15: v = 8'h52;
      6'd24: v = 8'd8;   6'd25: v = 8'd2;
      6'd37: v = 8'h49;  6'd38: v = 8'h44; 6'd39: v = 8'h41; 6'd40: v = 8'h54;
      6'd41: v = 8'h78;  6'd42: v = 8'h01;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/pngse_regs.sv]
// APB register file for image geometry.
`timescale 1ns / 1ps
module pngse_regs
  import pngse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [CfgWidth-1:0] image_width,
  output logic [CfgWidth-1:0] image_height
);

  logic wr;
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CfgWidth'(1);
      image_height <= CfgWidth'(1);
    end else if (wr) begin
      if (paddr == AddrWidth) image_width <= pwdata[CfgWidth-1:0];
      if (paddr == AddrHeight) image_height <= pwdata[CfgWidth-1:0];
    end
  end

  always_comb begin
    case (paddr)
      AddrWidth:  prdata = {{(32-CfgWidth){1'b0}}, image_width};
      AddrHeight: prdata = {{(32-CfgWidth){1'b0}}, image_height};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

[rtl/core/pngse_sum.sv]
// Shared checksum unit: header CRC, IDAT CRC and Adler-32, one byte per cycle while enabled.
`timescale 1ns / 1ps
module pngse_sum
  import pngse_pkg::*;
(
  input  logic            clk,
  input  pngse_sum_ctrl_t ctrl,
  input  logic [7:0]      data,
  output logic [31:0]     hdr_crc,
  output logic [31:0]     body_crc,
  output logic [31:0]     adler
);

  logic [31:0] crc_in, crc_out;
  logic [15:0] adler_low, adler_high;
  logic [16:0] low_sum, high_sum;
  logic [15:0] low_next;

  // one CRC stepper serves both chunk accumulators
  assign crc_in  = ctrl.hdr_en ? hdr_crc : body_crc;
  assign crc_out = crc_byte(crc_in, data);

  always_comb begin
    low_sum  = {1'b0, adler_low} + {9'd0, data};
    low_next = (low_sum >= AdlerMod) ? 16'(low_sum - AdlerMod) : low_sum[15:0];
    high_sum = {1'b0, adler_high} + {1'b0, low_next};
  end

  assign adler = {adler_high, adler_low};

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      hdr_crc    <= 32'hffffffff;
      body_crc   <= 32'hffffffff;
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
    end else begin
      if (ctrl.hdr_en) hdr_crc <= crc_out;
      if (ctrl.idat_en) body_crc <= crc_out;
      if (ctrl.adler_en) begin
        adler_low  <= low_next;
        adler_high <= (high_sum >= AdlerMod) ? 16'(high_sum - AdlerMod) : high_sum[15:0];
      end
    end
  end

endmodule

[rtl/core/png_stored_rgb_stream_encoder.sv]
// Top level: byte sequencer turning RGB565 pixels into a stored-zlib PNG stream.
//
//  channel  | signals                         | moves
//  in       | in_valid, in_ready, in_data     | start or pixel transaction
//  out      | out_valid, out_ready, out_data  | one file byte per transaction
//  cfg      | psel..pready (APB)              | image_width @0, image_height @4
//
// One byte leaves per cycle through the output register after the accepting
// cycle: a start emits 43 bytes, a pixel 3 (9 on a row's first pixel), the
// last pixel 20 more. The byte sequencer and its one CRC/Adler stepper set
// that rate. in_ready is high only while no burst is running; a stalled
// output holds the sequencer. Reset (rst, synchronous) returns to idle with
// no frame open.
`timescale 1ns / 1ps
module png_stored_rgb_stream_encoder
  import pngse_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pngse_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pngse_out_t  out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CfgWidth-1:0] image_width, image_height;
  pngse_state_t state;
  logic [5:0]   cnt;
  logic         frame_active;
  logic [WW-1:0] fw, col;
  logic [HW-1:0] fh, row;
  logic [15:0]  pix;
  logic [31:0]  idat_len;
  logic [31:0]  hdr_crc, body_crc, adler;
  logic [31:0]  fw32, fh32, hcrc_x, icrc_x, rowb;
  logic [15:0]  len, nlen;
  logic         accept, advance, last_row;
  logic [7:0]   byte_val;
  logic         rl, fl;
  pngse_sum_ctrl_t sum_ctrl;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;

  pngse_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .image_width, .image_height
  );

  pngse_sum u_sum (
    .clk, .ctrl(sum_ctrl), .data(byte_val), .hdr_crc, .body_crc, .adler
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign advance  = !out_valid || out_ready;
  assign fw32     = 32'(fw);
  assign fh32     = 32'(fh);
  assign hcrc_x   = ~hdr_crc;
  assign icrc_x   = ~body_crc;
  assign rowb     = (fw32 << 1) + fw32 + 32'd6;
  assign len      = 16'((fw32 << 1) + fw32 + 32'd1);
  assign nlen     = ~len;
  assign col_inc  = col + WW'(1);
  assign row_inc  = row + HW'(1);
  assign last_row = (row_inc == fh);

  always_ff @(posedge clk) begin
    idat_len <= 32'd6 + 32'(fh32 * rowb);
  end

  // byte value and flags for the current sequencer step
  always_comb begin
    byte_val = 8'd0;
    rl = 1'b0;
    fl = 1'b0;
    sum_ctrl = '0;
    sum_ctrl.init = accept && !in_data.operation;
    case (state)
      ST_HEAD: begin
        case (cnt)
          6'd16: byte_val = fw32[31:24];
          6'd17: byte_val = fw32[23:16];
          6'd18: byte_val = fw32[15:8];
          6'd19: byte_val = fw32[7:0];
          6'd20: byte_val = fh32[31:24];
          6'd21: byte_val = fh32[23:16];
          6'd22: byte_val = fh32[15:8];
          6'd23: byte_val = fh32[7:0];
          6'd29: byte_val = hcrc_x[31:24];
          6'd30: byte_val = hcrc_x[23:16];
          6'd31: byte_val = hcrc_x[15:8];
          6'd32: byte_val = hcrc_x[7:0];
          6'd33: byte_val = idat_len[31:24];
          6'd34: byte_val = idat_len[23:16];
          6'd35: byte_val = idat_len[15:8];
          6'd36: byte_val = idat_len[7:0];
          default: byte_val = head_const(cnt);
        endcase
        sum_ctrl.hdr_en  = advance && cnt >= 6'd12 && cnt <= 6'd28;
        sum_ctrl.idat_en = advance && cnt >= 6'd37;
        rl = (cnt == 6'd42);
      end
      ST_ROWH: begin
        case (cnt)
          6'd0: byte_val = {7'd0, last_row};
          6'd1: byte_val = len[7:0];
          6'd2: byte_val = len[15:8];
          6'd3: byte_val = nlen[7:0];
          6'd4: byte_val = nlen[15:8];
          default: byte_val = 8'd0;
        endcase
        sum_ctrl.idat_en  = advance;
        sum_ctrl.adler_en = advance && cnt == 6'd5;
      end
      ST_PIX: begin
        case (cnt)
          6'd0: byte_val = {pix[15:11], pix[15:13]};
          6'd1: byte_val = {pix[10:5], pix[10:9]};
          default: byte_val = {pix[4:0], pix[4:2]};
        endcase
        sum_ctrl.idat_en  = advance;
        sum_ctrl.adler_en = advance;
        rl = (cnt == 6'd2) && !(col_inc == fw && last_row);
      end
      ST_TAIL: begin
        case (cnt)
          6'd0: byte_val = adler[31:24];
          6'd1: byte_val = adler[23:16];
          6'd2: byte_val = adler[15:8];
          6'd3: byte_val = adler[7:0];
          6'd4: byte_val = icrc_x[31:24];
          6'd5: byte_val = icrc_x[23:16];
          6'd6: byte_val = icrc_x[15:8];
          6'd7: byte_val = icrc_x[7:0];
          6'd12: byte_val = 8'h49;
          6'd13: byte_val = 8'h45;
          6'd14: byte_val = 8'h4e;
          6'd15: byte_val = 8'h44;
          6'd16: byte_val = 8'hae;
          6'd17: byte_val = 8'h42;
          6'd18: byte_val = 8'h60;
          6'd19: byte_val = 8'h82;
          default: byte_val = 8'd0;
        endcase
        sum_ctrl.idat_en = advance && cnt <= 6'd3;
        rl = (cnt == 6'd19);
        fl = (cnt == 6'd19);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= 6'd0;
      frame_active <= 1'b0;
      out_valid    <= 1'b0;
      fw           <= WW'(1);
      fh           <= HW'(1);
      col          <= '0;
      row          <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept) begin
        cnt <= 6'd0;
        pix <= in_data.pixel;
        if (!in_data.operation) begin
          // latch clamped geometry for the whole file
          if (image_width == '0) fw <= WW'(1);
          else if (32'(image_width) > MAX_WIDTH) fw <= WW'(MAX_WIDTH);
          else fw <= WW'(image_width);
          if (image_height == '0) fh <= HW'(1);
          else if (32'(image_height) > MAX_HEIGHT) fh <= HW'(MAX_HEIGHT);
          else fh <= HW'(image_height);
          col          <= '0;
          row          <= '0;
          frame_active <= 1'b1;
          state        <= ST_HEAD;
        end else if (frame_active) begin
          state <= (col == '0) ? ST_ROWH : ST_PIX;
        end
      end else if (state != ST_IDLE && advance) begin
        out_valid          <= 1'b1;
        out_data.out_byte  <= byte_val;
        out_data.run_last  <= rl;
        out_data.file_last <= fl;
        cnt <= cnt + 6'd1;
        case (state)
          ST_HEAD: if (cnt == 6'd42) state <= ST_IDLE;
          ST_ROWH: if (cnt == 6'd5) begin
            cnt   <= 6'd0;
            state <= ST_PIX;
          end
          ST_PIX: if (cnt == 6'd2) begin
            cnt   <= 6'd0;
            state <= ST_IDLE;
            if (col_inc == fw) begin
              col <= '0;
              row <= row_inc;
              if (last_row) state <= ST_TAIL;
            end else begin
              col <= col_inc;
            end
          end
          ST_TAIL: if (cnt == 6'd19) begin
            state        <= ST_IDLE;
            frame_active <= 1'b0;
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  a_file_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.file_last |-> out_data.run_last)
    else $error("file_last without run_last");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("input ready during a burst");

  a_tail_in_frame: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAIL |-> frame_active)
    else $error("trailer outside a frame");

  a_file_end_closes: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAIL && cnt == 6'd19 && advance |=> !frame_active)
    else $error("frame still open after trailer");

endmodule

[test/tb_png_stored_rgb_stream_encoder.sv]
// Testbench: drives starts and pixels into the PNG encoder and checks every file byte.
`timescale 1ns / 1ps
module tb_png_stored_rgb_stream_encoder
  import pngse_pkg::*;
;

  // Byte-level predictor of the encoder; holds the expected byte queue.
  class png_byte_scoreboard;
    int unsigned cfg_w = 1, cfg_h = 1;
    bit frame_open;
    logic [31:0] body_crc;
    logic [15:0] ad_lo, ad_hi;
    int unsigned col, row, fw, fh;
    pngse_out_t pending[$];
    int errors;

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      c ^= {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
      return c;
    endfunction

    function void push(logic [7:0] b);
      pngse_out_t o;
      o.out_byte = b;
      o.run_last = 1'b0;
      o.file_last = 1'b0;
      pending.push_back(o);
    endfunction

    function void push32(logic [31:0] v);
      push(v[31:24]); push(v[23:16]); push(v[15:8]); push(v[7:0]);
    endfunction

    function void push_idat(logic [7:0] b);
      push(b);
      body_crc = crc_step(body_crc, b);
    endfunction

    function void push_zdata(logic [7:0] b);
      int unsigned lo, hi;
      push_idat(b);
      lo = ad_lo + b;
      if (lo >= 65521) lo -= 65521;
      hi = ad_hi + lo;
      if (hi >= 65521) hi -= 65521;
      ad_lo = lo[15:0];
      ad_hi = hi[15:0];
    endfunction

    function int unsigned clamp(int unsigned v);
      if (v == 0) return 1;
      return (v > 4096) ? 4096 : v;
    endfunction

    function void start_file();
      logic [31:0] c;
      logic [7:0] hdr[13];
      logic [7:0] sig[8] = '{137, 80, 78, 71, 13, 10, 26, 10};
      logic [7:0] tag_ihdr[4] = '{8'h49, 8'h48, 8'h44, 8'h52};
      logic [7:0] tag_idat[4] = '{8'h49, 8'h44, 8'h41, 8'h54};
      fw = clamp(cfg_w);
      fh = clamp(cfg_h);
      foreach (sig[i]) push(sig[i]);
      push32(32'd13);
      c = '1;
      foreach (tag_ihdr[i]) begin push(tag_ihdr[i]); c = crc_step(c, tag_ihdr[i]); end
      {hdr[0], hdr[1], hdr[2], hdr[3]} = fw;
      {hdr[4], hdr[5], hdr[6], hdr[7]} = fh;
      hdr[8] = 8; hdr[9] = 2; hdr[10] = 0; hdr[11] = 0; hdr[12] = 0;
      foreach (hdr[i]) begin push(hdr[i]); c = crc_step(c, hdr[i]); end
      push32(~c);
      push32(6 + fh * (3 * fw + 6));
      body_crc = '1;
      foreach (tag_idat[i]) begin
        push(tag_idat[i]);
        body_crc = crc_step(body_crc, tag_idat[i]);
      end
      push_idat(8'h78);
      push_idat(8'h01);
      ad_lo = 1; ad_hi = 0; col = 0; row = 0;
      frame_open = 1;
    endfunction

    function void finish_file();
      logic [31:0] c;
      logic [7:0] tag_iend[4] = '{8'h49, 8'h45, 8'h4e, 8'h44};
      push_idat(ad_hi[15:8]); push_idat(ad_hi[7:0]);
      push_idat(ad_lo[15:8]); push_idat(ad_lo[7:0]);
      push32(~body_crc);
      push32(32'd0);
      c = '1;
      foreach (tag_iend[i]) begin push(tag_iend[i]); c = crc_step(c, tag_iend[i]); end
      push32(~c);
      pending[$].file_last = 1'b1;
      frame_open = 0;
    endfunction

    function void note_input(pngse_in_t it);
      int n;
      logic [15:0] len;
      logic [4:0] r, b;
      logic [5:0] g;
      n = pending.size();
      if (!it.operation) start_file();
      else if (frame_open) begin
        if (col == 0) begin
          len = 16'(1 + 3 * fw);
          push_idat((row + 1 == fh) ? 8'd1 : 8'd0);
          push_idat(len[7:0]); push_idat(len[15:8]);
          push_idat(~len[7:0]); push_idat(~len[15:8]);
          push_zdata(8'd0);
        end
        {r, g, b} = it.pixel;
        push_zdata({r, r[4:2]});
        push_zdata({g, g[5:4]});
        push_zdata({b, b[4:2]});
        col++;
        if (col >= fw) begin
          col = 0;
          row++;
          if (row >= fh) finish_file();
        end
      end
      if (pending.size() > n) pending[$].run_last = 1'b1;
    endfunction

    function void check_byte(pngse_out_t got);
      pngse_out_t exp_b;
      if (pending.size() == 0) begin
        $error("unexpected byte %h", got.out_byte);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (got.out_byte !== exp_b.out_byte) begin
        $error("out_byte expected %h got %h", exp_b.out_byte, got.out_byte); errors++;
      end
      if (got.run_last !== exp_b.run_last) begin
        $error("run_last expected %b got %b", exp_b.run_last, got.run_last); errors++;
      end
      if (got.file_last !== exp_b.file_last) begin
        $error("file_last expected %b got %b", exp_b.file_last, got.file_last); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  pngse_in_t in_data;
  pngse_out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  png_byte_scoreboard sb;
  bit idle_on = 1;
  int stall_cycles;

  png_stored_rgb_stream_encoder uut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sample transactions at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_byte(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles > 20000) begin
        $display("tb_png_stored_rgb_stream_encoder failed");
        $finish;
      end
    end
  end

  // Receiver: burst stalls while idling is enabled.
  initial begin
    int gap;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ready = 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 8);
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    if (addr == AddrWidth) sb.cfg_w = val & 32'h1fff;
    else sb.cfg_h = val & 32'h1fff;
  endtask

  task automatic send(bit op, logic [15:0] pix);
    if (idle_on && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    in_valid = 1;
    in_data.operation = op;
    in_data.pixel = pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned npix, bit random_pix);
    apb_write(AddrWidth, w);
    apb_write(AddrHeight, h);
    send(1'b0, 16'h0);
    for (int unsigned i = 0; i < npix; i++)
      send(1'b1, random_pix ? 16'($urandom) : ((i % 2) ? 16'hffff : 16'h0000));
    drain();
  endtask

  initial begin
    int items;
    int unsigned w, h;
    sb = new();
    rst = 1; in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (5) @(negedge clk);
    rst = 0;
    // directed: stray pixel while idle, reset geometry, zero and oversize dims
    send(1'b1, 16'h1234);
    send(1'b0, 16'h0);
    send(1'b1, 16'hffff);
    drain();
    run_frame(0, 0, 1, 0);
    run_frame(2, 2, 4, 0);
    run_frame(13'h1fff, 3, 2, 0);       // saturates, abandoned mid-row
    run_frame(4096, 13'h1fff, 1, 1);
    send(1'b0, 16'h0);                  // restart over an open frame
    drain();
    run_frame(3, 1, 3, 0);
    items = 25;
    while (items < 310) begin
      if (items > 250) idle_on = 0;
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) run_frame(w, h, $urandom_range(0, w * h), 1);
      else run_frame(w, h, w * h + $urandom_range(0, 2), 1);
      items += w * h + 1;
    end
    drain();
    if (sb.errors == 0) $display("tb_png_stored_rgb_stream_encoder passed");
    else $display("tb_png_stored_rgb_stream_encoder failed");
    $finish;
  end

endmodule

[png_stored_rgb_stream_encoder.f]
rtl/core/pngse_pkg.sv
rtl/core/pngse_regs.sv
rtl/core/pngse_sum.sv
rtl/core/png_stored_rgb_stream_encoder.sv
test/tb_png_stored_rgb_stream_encoder.sv
